>>> hw/rtl/haptic_pulse_pattern_sequencer_macros.svh
// Assertion macros for the haptic pulse pattern sequencer RTL.
`ifndef HAPTIC_PULSE_PATTERN_SEQUENCER_MACROS_SVH
`define HAPTIC_PULSE_PATTERN_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define HPPS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hpps assertion failed");
`define HPPS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hpps assertion failed");
`else
`define HPPS_ASSERT_IMP(label, ante, cons)
`define HPPS_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/hpps_pkg.sv
// Package with types, codes and segment functions of the haptic pulse pattern sequencer.
package hpps_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_HOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd5;

	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_REQUEST   = 2'd1;
	localparam logic [1:0] OP_FORCE_OFF = 2'd2;

	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_DUO  = 2'd2;
	localparam logic [1:0] LVL_LONG = 2'd3;

	localparam logic [3:0] PULSE_SEGS = 4'd6;
	localparam logic [3:0] DUO_SEGS   = 4'd13;
	localparam logic [3:0] SEG_GAP    = 4'd6;
	localparam logic [3:0] SEG_SECOND = 4'd7;

	localparam logic [3:0] POS_UP33 = 4'd0;
	localparam logic [3:0] POS_UP66 = 4'd1;
	localparam logic [3:0] POS_FULL = 4'd2;
	localparam logic [3:0] POS_HOLD = 4'd3;
	localparam logic [3:0] POS_DN66 = 4'd4;

	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	// Reciprocals of 100 that give exact quotients for 20-bit and 21-bit dividends.
	localparam logic [20:0] RECIP_100_K27 = 21'd1342178;
	localparam logic [21:0] RECIP_100_K28 = 22'd2684355;

	localparam logic [13:0] FULL_DUTY_RST  = 14'd8000;
	localparam logic [13:0] DUTY33_RST     = 14'd2640;
	localparam logic [13:0] DUTY66_RST     = 14'd5280;
	localparam logic [9:0]  RAMP_STEP_RST  = 10'd30;
	localparam logic [11:0] SHORT_HOLD_RST = 12'd180;
	localparam logic [11:0] LONG_HOLD_RST  = 12'd450;
	localparam logic [11:0] GAP_RST        = 12'd100;
	localparam logic [15:0] TIMEOUT_RST    = 16'd1000;

	typedef struct packed {
		logic [13:0] full_duty;
		logic [13:0] duty33;
		logic [13:0] duty66;
		logic [9:0]  ramp_step;
		logic [11:0] short_hold;
		logic [11:0] long_hold;
		logic [11:0] gap;
		logic [15:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic [11:0] ticks;
		logic [13:0] duty;
	} seg_t;

	typedef struct packed {
		logic        ok;
		logic [3:0]  seg;
		logic [11:0] ticks;
		logic [13:0] duty;
	} entry_t;

	typedef struct packed {
		logic [13:0] duty;
		logic        busy;
		logic        fin;
	} result_t;

	// floor(m * 33 / 100)
	function automatic logic [13:0] duty_pct33(input logic [13:0] m);
		logic [19:0] x;
		logic [40:0] p;
		x = ({6'b0, m} << 5) + {6'b0, m};
		p = {21'b0, x} * {20'b0, RECIP_100_K27};
		return p[40:27];
	endfunction

	// floor(m * 66 / 100)
	function automatic logic [13:0] duty_pct66(input logic [13:0] m);
		logic [20:0] x;
		logic [42:0] p;
		x = ({7'b0, m} << 6) + {6'b0, m, 1'b0};
		p = {22'b0, x} * {21'b0, RECIP_100_K28};
		return p[41:28];
	endfunction

	function automatic seg_t seg_info(input logic [3:0] idx, input logic [1:0] pl,
		input cfg_t c);
		logic [3:0]  pos;
		logic [11:0] ramp;
		logic [11:0] hold;
		seg_t        s;
		ramp = (c.ramp_step == '0) ? 12'd1 : {2'b0, c.ramp_step};
		hold = (pl == LVL_LONG) ? c.long_hold : c.short_hold;
		pos = idx;
		if (pl == LVL_DUO && idx >= PULSE_SEGS) begin
			pos = idx - SEG_SECOND;
		end
		case (pos)
			POS_UP33: s = '{ticks: ramp, duty: c.duty33};
			POS_UP66: s = '{ticks: ramp, duty: c.duty66};
			POS_FULL: s = '{ticks: ramp, duty: c.full_duty};
			POS_HOLD: s = '{ticks: hold, duty: c.full_duty};
			POS_DN66: s = '{ticks: ramp, duty: c.duty66};
			default:  s = '{ticks: ramp, duty: c.duty33};
		endcase
		if (pl == LVL_DUO && idx == SEG_GAP) begin
			s = '{ticks: c.gap, duty: 14'd0};
		end
		return s;
	endfunction

	// Only a hold or a gap can be empty, and a ramp always follows either,
	// so at most one segment is ever skipped.
	function automatic entry_t enter_from(input logic [3:0] idx, input logic [1:0] pl,
		input cfg_t c);
		logic [3:0] nseg;
		logic [3:0] idx1;
		seg_t       a;
		seg_t       b;
		entry_t     e;
		nseg = (pl == LVL_DUO) ? DUO_SEGS : PULSE_SEGS;
		idx1 = idx + 4'd1;
		a = seg_info(idx, pl, c);
		b = seg_info(idx1, pl, c);
		if (idx < nseg && a.ticks != '0) begin
			e = '{ok: 1'b1, seg: idx, ticks: a.ticks, duty: a.duty};
		end else if (idx1 < nseg && b.ticks != '0) begin
			e = '{ok: 1'b1, seg: idx1, ticks: b.ticks, duty: b.duty};
		end else begin
			e = '0;
		end
		return e;
	endfunction

endpackage

>>> hw/rtl/hpps_cfg.sv
// Configuration registers with the scaled 33% and 66% duty levels.
module hpps_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [hpps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hpps_pkg::CFG_DATA_W-1:0] cfg_data,
	output hpps_pkg::cfg_t                  cfg
);
	import hpps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_duty  <= FULL_DUTY_RST;
			cfg_q.duty33     <= DUTY33_RST;
			cfg_q.duty66     <= DUTY66_RST;
			cfg_q.ramp_step  <= RAMP_STEP_RST;
			cfg_q.short_hold <= SHORT_HOLD_RST;
			cfg_q.long_hold  <= LONG_HOLD_RST;
			cfg_q.gap        <= GAP_RST;
			cfg_q.timeout    <= TIMEOUT_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_FULL_DUTY: begin
					cfg_q.full_duty <= cfg_data[13:0];
					cfg_q.duty33    <= duty_pct33(cfg_data[13:0]);
					cfg_q.duty66    <= duty_pct66(cfg_data[13:0]);
				end
				REG_RAMP_STEP:  cfg_q.ramp_step  <= cfg_data[9:0];
				REG_SHORT_HOLD: cfg_q.short_hold <= cfg_data[11:0];
				REG_LONG_HOLD:  cfg_q.long_hold  <= cfg_data[11:0];
				REG_GAP:        cfg_q.gap        <= cfg_data[11:0];
				REG_TIMEOUT:    cfg_q.timeout    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/hpps_seq.sv
// Pattern state and the single-pass update for one transaction.
`include "haptic_pulse_pattern_sequencer_macros.svh"

module hpps_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [1:0]        op,
	input  logic [1:0]        lvl,
	input  hpps_pkg::cfg_t    cfg,
	output hpps_pkg::result_t res
);
	import hpps_pkg::*;

	logic [1:0]  pending_q;
	logic        busy_q;
	logic [1:0]  playing_q;
	logic [3:0]  seg_q;
	logic [11:0] ticks_q;
	logic [15:0] elapsed_q;
	logic [13:0] duty_q;

	logic [1:0]  pending_n;
	logic        busy_n;
	logic [1:0]  playing_n;
	logic [3:0]  seg_n;
	logic [11:0] ticks_n;
	logic [15:0] elapsed_n;
	logic [13:0] duty_n;
	logic        fin_n;

	always_comb begin
		logic [15:0] el_inc;
		logic [1:0]  lvl_max;
		entry_t      e;
		pending_n = pending_q;
		busy_n    = busy_q;
		playing_n = playing_q;
		seg_n     = seg_q;
		ticks_n   = ticks_q;
		elapsed_n = elapsed_q;
		duty_n    = duty_q;
		fin_n     = 1'b0;
		el_inc    = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
		lvl_max   = (lvl > pending_q) ? lvl : pending_q;
		e         = '0;
		case (op)
			OP_TICK: begin
				if (busy_q) begin
					e = enter_from(seg_q + 4'd1, playing_q, cfg);
					elapsed_n = el_inc;
					if (el_inc > cfg.timeout) begin
						fin_n = 1'b1;
					end else if (ticks_q <= 12'd1) begin
						if (e.ok) begin
							seg_n   = e.seg;
							ticks_n = e.ticks;
							duty_n  = e.duty;
						end else begin
							fin_n = 1'b1;
						end
					end else begin
						ticks_n = ticks_q - 12'd1;
					end
				end
			end
			OP_REQUEST: begin
				if (lvl != LVL_NONE) begin
					pending_n = lvl_max;
					if (!busy_q) begin
						e = enter_from(4'd0, lvl_max, cfg);
						pending_n = LVL_NONE;
						playing_n = lvl_max;
						busy_n    = 1'b1;
						elapsed_n = '0;
						seg_n     = e.seg;
						ticks_n   = e.ticks;
						duty_n    = e.duty;
					end
				end
			end
			OP_FORCE_OFF: fin_n = 1'b1;
			default: ;
		endcase
		// Every finish, whether timeout, end of pattern or force-off, clears the pattern.
		if (fin_n) begin
			busy_n    = 1'b0;
			playing_n = LVL_NONE;
			seg_n     = '0;
			ticks_n   = '0;
			elapsed_n = '0;
			duty_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= LVL_NONE;
			busy_q    <= 1'b0;
			playing_q <= LVL_NONE;
			seg_q     <= '0;
			ticks_q   <= '0;
			elapsed_q <= '0;
			duty_q    <= '0;
		end else if (step) begin
			pending_q <= pending_n;
			busy_q    <= busy_n;
			playing_q <= playing_n;
			seg_q     <= seg_n;
			ticks_q   <= ticks_n;
			elapsed_q <= elapsed_n;
			duty_q    <= duty_n;
		end
	end

	assign res = '{duty: duty_n, busy: busy_n, fin: fin_n};

	`HPPS_ASSERT_IMP(a_idle_no_duty, !busy_q, duty_q == '0 && ticks_q == '0)
	`HPPS_ASSERT_IMP(a_busy_seg_range, busy_q, seg_q < DUO_SEGS && ticks_q != '0)
	`HPPS_ASSERT_NXT(a_force_off_stops, step && op == OP_FORCE_OFF, !busy_q && duty_q == '0)
	`HPPS_ASSERT_IMP(a_fin_ends_busy, step && fin_n, !busy_n)

endmodule

>>> hw/rtl/haptic_pulse_pattern_sequencer.sv
// Top level of the haptic pulse pattern sequencer: input stage, sequencer and result register.
//
// Every accepted transaction (a millisecond tick, a level request or a force-off) yields exactly
// one result transaction carrying the motor duty in hundredths of a percent, the busy flag and a
// one-transaction finished flag. One transaction is taken per clock while not stalled; a
// transaction is registered on entry, the pattern state is updated in a single combinational
// pass, and the result is written to an output register at the clock edge after acceptance
// unless an earlier result is still stalled. Input and output stages both hold while the result
// is stalled, so a stalled result never loses or repeats a transaction. Configuration writes take
// effect at the next clock and must only be issued while no transaction is in flight.
module haptic_pulse_pattern_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [hpps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hpps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      operation,
	input  logic [1:0]                      level,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [13:0]                     duty_hundredths,
	output logic                            busy_res,
	output logic                            finished
);
	import hpps_pkg::*;

	cfg_t        cfg;
	result_t     res;
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [1:0]  lvl_s1;
	logic        advance;
	logic        out_valid_q;
	result_t     res_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= operation;
			lvl_s1 <= level;
		end
	end

	hpps_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	hpps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.op     (op_s1),
		.lvl    (lvl_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign duty_hundredths = res_q.duty;
	assign busy_res        = res_q.busy;
	assign finished        = res_q.fin;

endmodule

>>> verif/tb_haptic_pulse_pattern_sequencer.sv
// Self-checking testbench for the haptic pulse pattern sequencer with randomized handshakes.
`timescale 1ns / 100ps

module tb_haptic_pulse_pattern_sequencer;
	import hpps_pkg::*;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] LVL_SHORT  = 2'd1;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int PULSE_SEGMENTS = 6;
	localparam int DUO_SEGMENTS   = 13;
	localparam int GAP_SEGMENT    = 6;
	localparam int SECOND_PULSE   = 7;
	localparam int SETTLE_CYCLES  = 6;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] lvl;
	} motor_cmd_t;

	typedef struct packed {
		logic [13:0] duty;
		logic        busy;
		logic        fin;
	} motor_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [2:0]  cfg_index = REG_FULL_DUTY;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_TICK;
	logic [1:0]  level = LVL_NONE;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [13:0] duty_hundredths;
	logic        busy_res;
	logic        finished;

	haptic_pulse_pattern_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.level(level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.duty_hundredths(duty_hundredths),
		.busy_res(busy_res),
		.finished(finished)
	);

	// Predicted configuration.
	logic [13:0] cfg_full_duty = 14'd8000;
	logic [9:0]  cfg_ramp = 10'd30;
	logic [11:0] cfg_short_hold = 12'd180;
	logic [11:0] cfg_long_hold = 12'd450;
	logic [11:0] cfg_gap = 12'd100;
	logic [15:0] cfg_timeout = 16'd1000;

	// Predicted pattern state.
	logic [1:0]  pend_lvl = LVL_NONE;
	logic        playing = 1'b0;
	logic [1:0]  play_lvl = LVL_NONE;
	int          seg_idx = 0;
	logic [11:0] seg_left = '0;
	logic [15:0] elapsed = '0;
	logic [13:0] duty_reg = '0;

	motor_cmd_t    cmd_backlog[$];
	motor_report_t duty_reports_due[$];

	int cmds_queued = 0;
	int cmds_accepted = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int cfg_writes = 0;
	int burst_left = 0;
	int idle_left = 0;
	int stall_mode = 0;
	int stall_span = 0;
	int stall_run = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [13:0] scaled_duty(input int unsigned pct);
		return 14'((32'(cfg_full_duty) * pct) / 100);
	endfunction

	function automatic int unsigned segment_ticks(input int idx, output logic [13:0] d);
		int unsigned ramp;
		int unsigned hold;
		int pos;
		ramp = (cfg_ramp == '0) ? 1 : cfg_ramp;
		hold = (play_lvl == LVL_LONG) ? cfg_long_hold : cfg_short_hold;
		pos = idx;
		if (play_lvl == LVL_DUO && idx >= PULSE_SEGMENTS) begin
			if (idx == GAP_SEGMENT) begin
				d = '0;
				return cfg_gap;
			end
			pos = idx - SECOND_PULSE;
		end
		case (pos)
			0: begin
				d = scaled_duty(33);
				return ramp;
			end
			1: begin
				d = scaled_duty(66);
				return ramp;
			end
			2: begin
				d = cfg_full_duty;
				return ramp;
			end
			3: begin
				d = cfg_full_duty;
				return hold;
			end
			4: begin
				d = scaled_duty(66);
				return ramp;
			end
			default: begin
				d = scaled_duty(33);
				return ramp;
			end
		endcase
	endfunction

	function automatic void stop_pattern();
		playing = 1'b0;
		play_lvl = LVL_NONE;
		seg_idx = 0;
		seg_left = '0;
		elapsed = '0;
		duty_reg = '0;
	endfunction

	function automatic bit enter_segment(input int first);
		int last;
		int unsigned len;
		logic [13:0] d;
		last = (play_lvl == LVL_DUO) ? DUO_SEGMENTS : PULSE_SEGMENTS;
		for (int i = first; i < last; i++) begin
			len = segment_ticks(i, d);
			if (len > 0) begin
				seg_idx = i;
				seg_left = 12'(len);
				duty_reg = d;
				return 1'b1;
			end
		end
		stop_pattern();
		return 1'b0;
	endfunction

	task automatic sequence_motor(input logic [1:0] op, input logic [1:0] lvl);
		logic fin;
		motor_report_t r;
		fin = 1'b0;
		case (op)
			OP_TICK: begin
				if (playing) begin
					if (elapsed != ELAPSED_MAX) elapsed++;
					if (elapsed > cfg_timeout) begin
						stop_pattern();
						fin = 1'b1;
					end else if (seg_left <= 12'd1) begin
						if (!enter_segment(seg_idx + 1)) fin = 1'b1;
					end else begin
						seg_left--;
					end
				end
			end
			OP_REQUEST: begin
				if (lvl != LVL_NONE) begin
					if (lvl > pend_lvl) pend_lvl = lvl;
					if (!playing) begin
						play_lvl = pend_lvl;
						pend_lvl = LVL_NONE;
						playing = 1'b1;
						elapsed = '0;
						if (!enter_segment(0)) fin = 1'b1;
					end
				end
			end
			OP_FORCE_OFF: begin
				stop_pattern();
				fin = 1'b1;
			end
			default: ;
		endcase
		r.duty = duty_reg;
		r.busy = playing;
		r.fin = fin;
		duty_reports_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_TICK;
			level <= LVL_NONE;
		end else begin : drive
			motor_cmd_t cmd;
			if (in_valid && !in_stall) begin
				sequence_motor(operation, level);
				cmds_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cmd = cmd_backlog.pop_front();
					operation <= cmd.op;
					level <= cmd.lvl;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin : watch
			logic hold_off;
			motor_report_t want;
			if (out_valid && !out_stall) begin
				results_checked++;
				if (duty_reports_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result with none expected: duty %0d busy %0b fin %0b",
							$realtime, duty_hundredths, busy_res, finished);
					mismatch_count++;
				end else begin
					want = duty_reports_due.pop_front();
					if (want.duty !== duty_hundredths || want.busy !== busy_res ||
						want.fin !== finished) begin
						if (mismatch_count < 10)
							$display("%0t: expected duty %0d busy %0b fin %0b, got %0d %0b %0b",
								$realtime, want.duty, want.busy, want.fin,
								duty_hundredths, busy_res, finished);
						mismatch_count++;
					end
				end
			end
			if (stall_span == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_span = $urandom_range(20, 120);
			end else begin
				stall_span--;
			end
			case (stall_mode)
				0: hold_off = 1'b0;
				1: hold_off = ($urandom_range(0, 9) < 3);
				2: begin
					if (stall_run > 0) begin
						stall_run--;
						hold_off = 1'b1;
					end else if ($urandom_range(0, 7) == 0) begin
						stall_run = $urandom_range(1, 12);
						hold_off = 1'b1;
					end else begin
						hold_off = 1'b0;
					end
				end
				default: hold_off = ~out_stall;
			endcase
			out_stall <= hold_off;
		end
	end

	task automatic add_cmd(input logic [1:0] op, input logic [1:0] lvl);
		motor_cmd_t c;
		c.op = op;
		c.lvl = lvl;
		cmd_backlog.push_back(c);
		cmds_queued++;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || duty_reports_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FULL_DUTY:  cfg_full_duty = val[13:0];
			REG_RAMP_STEP:  cfg_ramp = val[9:0];
			REG_SHORT_HOLD: cfg_short_hold = val[11:0];
			REG_LONG_HOLD:  cfg_long_hold = val[11:0];
			REG_GAP:        cfg_gap = val[11:0];
			REG_TIMEOUT:    cfg_timeout = val;
			default: ;
		endcase
		cfg_writes++;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic set_config(input int md, input int rs, input int sh, input int lh,
		input int gp, input int to);
		write_reg(REG_FULL_DUTY, 16'(md));
		write_reg(REG_RAMP_STEP, 16'(rs));
		write_reg(REG_SHORT_HOLD, 16'(sh));
		write_reg(REG_LONG_HOLD, 16'(lh));
		write_reg(REG_GAP, 16'(gp));
		write_reg(REG_TIMEOUT, 16'(to));
	endtask

	// A request followed mostly by ticks, with the odd interruption mixed in.
	task automatic queue_episode();
		logic [1:0] lvl;
		int unsigned ramp;
		int unsigned span;
		int unsigned n;
		int unsigned r;
		lvl = 2'($urandom_range(1, 3));
		add_cmd(OP_REQUEST, lvl);
		ramp = (cfg_ramp == '0) ? 1 : cfg_ramp;
		span = 5 * ramp + ((lvl == LVL_LONG) ? cfg_long_hold : cfg_short_hold);
		if (lvl == LVL_DUO) span = 2 * span + cfg_gap;
		n = $urandom_range(span / 2, span + 3);
		if (n > 80) n = $urandom_range(20, 80);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 85) add_cmd(OP_TICK, 2'($urandom_range(0, 3)));
			else if (r < 91) add_cmd(OP_REQUEST, 2'($urandom_range(0, 3)));
			else if (r < 95) add_cmd(OP_FORCE_OFF, 2'($urandom_range(0, 3)));
			else add_cmd(OP_UNUSED, 2'($urandom_range(0, 3)));
		end
	endtask

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int phase_start;
		int md;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: idle tick, ignored and unused items, latched pending level.
		add_cmd(OP_TICK, LVL_NONE);
		add_cmd(OP_REQUEST, LVL_NONE);
		add_cmd(OP_UNUSED, LVL_LONG);
		add_cmd(OP_REQUEST, LVL_SHORT);
		add_cmd(OP_TICK, LVL_NONE);
		add_cmd(OP_TICK, LVL_LONG);
		add_cmd(OP_REQUEST, LVL_LONG);
		add_cmd(OP_FORCE_OFF, LVL_NONE);
		add_cmd(OP_FORCE_OFF, LVL_NONE);
		add_cmd(OP_REQUEST, LVL_DUO);
		add_cmd(OP_FORCE_OFF, LVL_SHORT);
		wait_idle();

		// Zero ramp, empty hold and gap, full-scale duty, timeout that never fires.
		set_config(16383, 0, 0, 0, 0, 65535);
		write_reg(REG_UNUSED, 16'hFFFF);
		add_cmd(OP_REQUEST, LVL_DUO);
		for (int k = 0; k < 11; k++) add_cmd(OP_TICK, LVL_NONE);
		wait_idle();

		// Zero duty and a timeout of 1.
		set_config(0, 1, 2, 3, 1, 1);
		add_cmd(OP_REQUEST, LVL_SHORT);
		add_cmd(OP_TICK, LVL_NONE);
		add_cmd(OP_TICK, LVL_NONE);
		add_cmd(OP_TICK, LVL_NONE);
		wait_idle();

		for (int p = 0; p < 5; p++) begin
			case ($urandom_range(0, 3))
				0: md = 10000;
				1: md = 16383;
				default: md = $urandom_range(0, 16383);
			endcase
			set_config(md, $urandom_range(0, 4), $urandom_range(0, 6), $urandom_range(0, 10),
				$urandom_range(0, 5),
				($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(1, 40));
			phase_start = cmds_queued;
			while (cmds_queued - phase_start < 70) queue_episode();
			wait_idle();
		end

		// Longest segments: only the start of each pattern can be reached.
		set_config(16383, 1023, 4095, 4095, 4095, 65534);
		phase_start = cmds_queued;
		while (cmds_queued - phase_start < 40) queue_episode();
		wait_idle();

		set_config(9999, 0, 1, 0, 2, 5);
		phase_start = cmds_queued;
		while (cmds_queued - phase_start < 70) queue_episode();
		wait_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d ticks, requests and force-offs over %0d register writes.",
			cmds_accepted, cfg_writes);
		$display("Checked %0d results; %0d mismatched, %0d still outstanding.",
			results_checked, mismatch_count, duty_reports_due.size());
		if (mismatch_count == 0 && duty_reports_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hpps_pkg.sv
hw/rtl/hpps_cfg.sv
hw/rtl/hpps_seq.sv
hw/rtl/haptic_pulse_pattern_sequencer.sv
verif/tb_haptic_pulse_pattern_sequencer.sv
